### rtl/core/dapid_pkg.sv
// ============================================================================
// Dual-axis PID controller package
// Shared constants, register indexes and the microcode table of the
// controller sequencer.
// ============================================================================
package dapid_pkg;

    // Default parameter values
    localparam int ANGLE_WIDTH_DEF    = 16;
    localparam int GAIN_FRAC_BITS_DEF = 8;

    // Fixed field widths
    localparam int REG_W      = 16;  // every configuration register
    localparam int DRIVE_W    = 32;  // drive output / integral
    localparam int INTEG_FRAC = 16;  // fraction bits of the integral

    // Configuration port
    localparam int CFG_ADDR_W = 3;
    localparam logic [CFG_ADDR_W-1:0] REG_GAIN_PROP   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_GAIN_INTEG  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_GAIN_DERIV  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_TARGET_X    = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_TARGET_Y    = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_SAMPLE_PER  = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_SAMPLE_RATE = 3'd6;

    // Register reset values
    localparam logic [REG_W-1:0] SAMPLE_PER_RST  = 16'd655;
    localparam logic [REG_W-1:0] SAMPLE_RATE_RST = 16'd100;

    // Sequencer state
    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } t_seq_state;

    // Microcode fields
    typedef enum logic {
        SEQ_NEXT = 1'b0,   // go to the following step
        SEQ_LOOP = 1'b1    // X axis: jump to target for Y; Y axis: finish item
    } t_seq_op;

    typedef enum logic [2:0] {
        MUL_NONE       = 3'd0,
        MUL_PERIOD_ERR = 3'd1,
        MUL_RATE_DIFF  = 3'd2,
        MUL_GP_ERR     = 3'd3,
        MUL_GI_INT     = 3'd4,
        MUL_GD_DER     = 3'd5
    } t_mul_sel;

    typedef enum logic [1:0] {
        ACC_NONE    = 2'd0,
        ACC_LOAD    = 2'd1,  // acc = product
        ACC_ADD_INT = 2'd2,  // acc += round(product / 2^16)
        ACC_ADD     = 2'd3   // acc += product
    } t_acc_op;

    localparam int UC_STEP_W = 3;

    typedef struct packed {
        t_seq_op                seq;
        logic [UC_STEP_W-1:0]   jump_to;
        logic                   ld_err;  // error = angle - target
        logic                   diff;    // error delta, store last error
        logic                   integ;   // integral update from product
        logic                   clamp;   // derivative from product
        t_mul_sel               mul;
        t_acc_op                acc;
        logic                   drive;   // round, saturate, write drive
    } t_ucode;

    localparam t_ucode UC_NOP = '{
        seq: SEQ_NEXT, jump_to: '0, ld_err: 1'b0, diff: 1'b0, integ: 1'b0,
        clamp: 1'b0, mul: MUL_NONE, acc: ACC_NONE, drive: 1'b0
    };

    // One pass of the program handles one axis
    function automatic t_ucode ucode_rom(input logic [UC_STEP_W-1:0] step);
        t_ucode uc;
        uc = UC_NOP;
        case (step)
            3'd0: uc.ld_err = 1'b1;
            3'd1: begin
                uc.diff = 1'b1;
                uc.mul  = MUL_PERIOD_ERR;
            end
            3'd2: begin
                uc.integ = 1'b1;
                uc.mul   = MUL_RATE_DIFF;
            end
            3'd3: begin
                uc.clamp = 1'b1;
                uc.mul   = MUL_GP_ERR;
            end
            3'd4: begin
                uc.acc = ACC_LOAD;
                uc.mul = MUL_GI_INT;
            end
            3'd5: begin
                uc.acc = ACC_ADD_INT;
                uc.mul = MUL_GD_DER;
            end
            3'd6: uc.acc = ACC_ADD;
            3'd7: begin
                uc.drive   = 1'b1;
                uc.seq     = SEQ_LOOP;
                uc.jump_to = 3'd0;
            end
            default: uc = UC_NOP;
        endcase
        return uc;
    endfunction

endpackage

### rtl/core/dual_axis_pid_controller_core.sv
// ============================================================================
// Dual-axis PID controller core
// Discrete PID loop for two axes on one shared multiplier, run by a
// microcoded sequencer.
// ============================================================================
// Usage:
//   s_axis carries one item per transfer: angle_x in the low ANGLE_WIDTH bits
//   of tdata, angle_y above it. m_axis returns drive_x (bits 31:0) and
//   drive_y (bits 63:32), one result per input item, in order.
//   Gains, targets, sample period and sample rate are written through the
//   i_cfg_* port while the block is idle; index 7 is ignored.
// Timing:
//   An item's result is shown after an 8-step microprogram has run once
//   per axis. Every step does at most one pass through the shared
//   multiplier, so the microprogram length sets the rate; a new item is
//   taken only in the idle state, after the last one is finished.
// Reset (synchronous, active low):
//   Integrals and last errors clear, registers return to their defaults,
//   no result is pending.
// Stall:
//   The result sits in an output register; the next item is taken and
//   worked on meanwhile. If the result is still not taken when the next one
//   is finished, the sequencer holds on its last step.
// ============================================================================
module dual_axis_pid_controller_core #(
    parameter int ANGLE_WIDTH    = dapid_pkg::ANGLE_WIDTH_DEF,
    parameter int GAIN_FRAC_BITS = dapid_pkg::GAIN_FRAC_BITS_DEF,
    localparam int IN_TW         = ((2 * ANGLE_WIDTH + 7) / 8) * 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // s_axis_tdata: angle_x, angle_y
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [IN_TW-1:0]                  s_axis_tdata,
    // m_axis_tdata: drive_x, drive_y
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [2*dapid_pkg::DRIVE_W-1:0]   m_axis_tdata,
    input  logic                              i_cfg_wr_en,
    input  logic [dapid_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [dapid_pkg::REG_W-1:0]       i_cfg_wdata
);

    // Widths of the datapath
    localparam int AW      = ANGLE_WIDTH;
    localparam int EW      = ((AW > dapid_pkg::REG_W) ? AW : dapid_pkg::REG_W) + 1;
    localparam int DFW     = EW + 1;
    localparam int DVW_RAW = DFW + dapid_pkg::REG_W + 1;
    localparam int DVW     = (DVW_RAW > 49) ? 49 : DVW_RAW;
    localparam int MA      = DVW;
    localparam int MB      = dapid_pkg::REG_W + 1;
    localparam int PW      = MA + MB;
    localparam int ACW     = PW + 2;
    localparam int DW      = dapid_pkg::DRIVE_W;

    localparam logic signed [PW-1:0]  DLIM_P = PW'(48'h8000_0000_0000);
    localparam logic signed [PW-1:0]  DLIM_N = -DLIM_P;
    localparam logic signed [PW-1:0]  RND_I  = PW'(32'd1 << (dapid_pkg::INTEG_FRAC - 1));
    localparam logic signed [ACW-1:0] RND_G  = ACW'((64'd1 << GAIN_FRAC_BITS) >> 1);
    localparam logic signed [ACW-1:0] SAT_HI = ACW'(32'sh7FFF_FFFF);
    localparam logic signed [ACW-1:0] SAT_LO = ACW'(32'sh8000_0000);

    function automatic logic signed [DW-1:0] sat32(input logic signed [ACW-1:0] v);
        if (v > SAT_HI) begin
            return 32'sh7FFF_FFFF;
        end else if (v < SAT_LO) begin
            return 32'sh8000_0000;
        end
        return v[DW-1:0];
    endfunction

    // Configuration registers
    logic signed [dapid_pkg::REG_W-1:0] r_gain_p, r_gain_i, r_gain_d;
    logic signed [dapid_pkg::REG_W-1:0] r_target_x, r_target_y;
    logic        [dapid_pkg::REG_W-1:0] r_period, r_rate;

    // Controller state
    logic signed [DW-1:0] r_integ_x, r_integ_y;
    logic signed [EW-1:0] r_prev_x, r_prev_y;

    // Sequencer
    dapid_pkg::t_seq_state              r_state, n_state;
    logic [dapid_pkg::UC_STEP_W-1:0]    r_step, n_step;
    logic                               r_axis, n_axis;
    dapid_pkg::t_ucode                  uc;
    logic                               emit_ok, stall, accept, emit;

    // Datapath registers
    logic signed [AW-1:0]  r_ang_x, r_ang_y;
    logic signed [EW-1:0]  r_err;
    logic signed [DFW-1:0] r_diff;
    logic signed [DVW-1:0] r_deriv;
    logic signed [PW-1:0]  r_prod;
    logic signed [ACW-1:0] r_acc;
    logic signed [DW-1:0]  r_drive_x;
    logic signed [DW-1:0]  r_out_x, r_out_y;
    logic                  r_out_valid;

    // Datapath intermediates
    logic signed [AW-1:0]               ang_sel;
    logic signed [dapid_pkg::REG_W-1:0] target_sel;
    logic signed [DW-1:0]               integ_sel;
    logic signed [EW-1:0]               prev_sel;
    logic signed [MA-1:0]               mul_a;
    logic signed [MB-1:0]               mul_b;
    logic signed [PW-1:0]               mul_p;
    logic signed [PW:0]                 integ_sum;
    logic signed [DW-1:0]               integ_new;
    logic signed [PW-1:0]               deriv_clamped;
    logic signed [PW-1:0]               int_term;
    logic signed [ACW-1:0]              acc_rnd;
    logic signed [DW-1:0]               drive_new;

    // Handshakes
    assign s_axis_tready = (r_state == dapid_pkg::ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_y, r_out_x};

    // Control word of the current step
    assign uc      = dapid_pkg::ucode_rom(r_step);
    assign emit_ok = !r_out_valid || m_axis_tready;
    assign stall   = (r_state == dapid_pkg::ST_RUN) && (uc.seq == dapid_pkg::SEQ_LOOP)
                     && r_axis && !emit_ok;
    assign emit    = (r_state == dapid_pkg::ST_RUN) && (uc.seq == dapid_pkg::SEQ_LOOP)
                     && r_axis && emit_ok;

    // Step counter and conditional jump
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_axis  = r_axis;
        unique case (r_state)
            dapid_pkg::ST_IDLE: begin
                if (accept) begin
                    n_state = dapid_pkg::ST_RUN;
                    n_step  = '0;
                    n_axis  = 1'b0;
                end
            end
            dapid_pkg::ST_RUN: begin
                if (!stall) begin
                    if (uc.seq == dapid_pkg::SEQ_NEXT) begin
                        n_step = r_step + 1'b1;
                    end else if (!r_axis) begin
                        n_axis = 1'b1;
                        n_step = uc.jump_to;
                    end else begin
                        n_state = dapid_pkg::ST_IDLE;
                    end
                end
            end
            default: n_state = dapid_pkg::ST_IDLE;
        endcase
    end

    // Axis selection
    assign ang_sel    = r_axis ? r_ang_y : r_ang_x;
    assign target_sel = r_axis ? r_target_y : r_target_x;
    assign integ_sel  = r_axis ? r_integ_y : r_integ_x;
    assign prev_sel   = r_axis ? r_prev_y : r_prev_x;

    // Shared multiplier operands
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (uc.mul)
            dapid_pkg::MUL_NONE: begin
                mul_a = '0;
                mul_b = '0;
            end
            dapid_pkg::MUL_PERIOD_ERR: begin
                mul_a = MA'(r_err);
                mul_b = $signed({1'b0, r_period});
            end
            dapid_pkg::MUL_RATE_DIFF: begin
                mul_a = MA'(r_diff);
                mul_b = $signed({1'b0, r_rate});
            end
            dapid_pkg::MUL_GP_ERR: begin
                mul_a = MA'(r_err);
                mul_b = MB'(r_gain_p);
            end
            dapid_pkg::MUL_GI_INT: begin
                mul_a = MA'(integ_sel);
                mul_b = MB'(r_gain_i);
            end
            dapid_pkg::MUL_GD_DER: begin
                mul_a = MA'(r_deriv);
                mul_b = MB'(r_gain_d);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Saturating integral
    assign integ_sum = (PW + 1)'(integ_sel) + (PW + 1)'(r_prod);
    assign integ_new = sat32(ACW'(integ_sum));

    // Derivative clamp
    always_comb begin
        if (r_prod > DLIM_P) begin
            deriv_clamped = DLIM_P;
        end else if (r_prod < DLIM_N) begin
            deriv_clamped = DLIM_N;
        end else begin
            deriv_clamped = r_prod;
        end
    end

    // Integral term back to gain scale, round half up
    assign int_term = (r_prod + RND_I) >>> dapid_pkg::INTEG_FRAC;

    // Final round and saturate
    assign acc_rnd   = (r_acc + RND_G) >>> GAIN_FRAC_BITS;
    assign drive_new = sat32(acc_rnd);

    // Control registers and state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dapid_pkg::ST_IDLE;
            r_step      <= '0;
            r_axis      <= 1'b0;
            r_out_valid <= 1'b0;
            r_integ_x   <= '0;
            r_integ_y   <= '0;
            r_prev_x    <= '0;
            r_prev_y    <= '0;
            r_gain_p    <= '0;
            r_gain_i    <= '0;
            r_gain_d    <= '0;
            r_target_x  <= '0;
            r_target_y  <= '0;
            r_period    <= dapid_pkg::SAMPLE_PER_RST;
            r_rate      <= dapid_pkg::SAMPLE_RATE_RST;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_axis  <= n_axis;

            // Output register
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            // Per-axis state
            if (r_state == dapid_pkg::ST_RUN && uc.diff) begin
                if (r_axis) begin
                    r_prev_y <= r_err;
                end else begin
                    r_prev_x <= r_err;
                end
            end
            if (r_state == dapid_pkg::ST_RUN && uc.integ) begin
                if (r_axis) begin
                    r_integ_y <= integ_new;
                end else begin
                    r_integ_x <= integ_new;
                end
            end

            // Register writes
            if (i_cfg_wr_en) begin
                unique case (i_cfg_addr)
                    dapid_pkg::REG_GAIN_PROP:   r_gain_p   <= i_cfg_wdata;
                    dapid_pkg::REG_GAIN_INTEG:  r_gain_i   <= i_cfg_wdata;
                    dapid_pkg::REG_GAIN_DERIV:  r_gain_d   <= i_cfg_wdata;
                    dapid_pkg::REG_TARGET_X:    r_target_x <= i_cfg_wdata;
                    dapid_pkg::REG_TARGET_Y:    r_target_y <= i_cfg_wdata;
                    dapid_pkg::REG_SAMPLE_PER:  r_period   <= i_cfg_wdata;
                    dapid_pkg::REG_SAMPLE_RATE: r_rate     <= i_cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ang_x <= s_axis_tdata[AW-1:0];
            r_ang_y <= s_axis_tdata[2*AW-1:AW];
        end
        if (r_state == dapid_pkg::ST_RUN) begin
            if (uc.ld_err) begin
                r_err <= EW'(ang_sel) - EW'(target_sel);
            end
            if (uc.diff) begin
                r_diff <= DFW'(r_err) - DFW'(prev_sel);
            end
            if (uc.clamp) begin
                r_deriv <= deriv_clamped[DVW-1:0];
            end
            if (uc.mul != dapid_pkg::MUL_NONE) begin
                r_prod <= mul_p;
            end
            case (uc.acc)
                dapid_pkg::ACC_LOAD:    r_acc <= ACW'(r_prod);
                dapid_pkg::ACC_ADD_INT: r_acc <= r_acc + ACW'(int_term);
                dapid_pkg::ACC_ADD:     r_acc <= r_acc + ACW'(r_prod);
                default: ;
            endcase
            if (uc.drive && !r_axis) begin
                r_drive_x <= drive_new;
            end
            if (emit) begin
                r_out_x <= r_drive_x;
                r_out_y <= drive_new;
            end
        end
    end

endmodule

### rtl/core/dapid_checker.sv
// ============================================================================
// Dual-axis PID controller port checker
// Watches the stream ports of the core over time; bound to the core module.
// ============================================================================
module dapid_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata
);

    // Reset leaves the block ready with nothing pending
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> s_axis_tready && !m_axis_tvalid)
        else $error("core not idle after reset");

    // One item at a time: no new transfer in the cycle after one
    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while an item is in work");

    // A result never appears right after an input transfer
    a_no_early_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
        else $error("result shown too early");

    // A stalled result holds its data
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

endmodule

bind dual_axis_pid_controller_core dapid_checker u_dapid_checker (.*);
